FILE: rtl/byterun1_row_packer_core_defines.svh
// Assertion macros for the run-length row packer.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef BYTERUN1_ROW_PACKER_CORE_DEFINES_SVH
`define BYTERUN1_ROW_PACKER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge out of reset
`define BR1RP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check that a condition holds in the cycle after a trigger
`define BR1RP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error(msg);
`else
`define BR1RP_ASSERT(lbl, prop, msg)
`define BR1RP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/br1rp_pkg.sv
// Shared constants and types of the run-length row packer.
// No dependencies; every module imports this package and the interfaces use it.
`timescale 1ns / 1ps
package br1rp_pkg;

    localparam int LITERAL_MAX = 128;
    localparam int RUN_MAX     = 128;
    localparam int MIN_RUN     = 3;
    localparam int OUT_LANES   = 8;
    localparam int STORE_DEPTH = LITERAL_MAX + 1;
    localparam int BYTE_W      = 8;
    localparam int FILL_W      = 8;
    localparam int LEN_W       = 13;
    localparam int CNT_W       = 4;
    localparam int LANE_W      = $clog2(OUT_LANES);
    localparam int STORE_ROWS  = (STORE_DEPTH + OUT_LANES - 1) / OUT_LANES;
    localparam int ROW_W       = FILL_W - LANE_W;
    localparam int WORD_W      = OUT_LANES * BYTE_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [OUT_LANES-1:0][BYTE_W-1:0] row_t;

    typedef enum logic [1:0] {
        PK_NONE = 2'd0,
        PK_LIT  = 2'd1,
        PK_RUN  = 2'd2
    } pkt_kind_t;

    // One packet: literal (hdr = n-1, bytes from the store) or run (hdr, value)
    typedef struct packed {
        pkt_kind_t kind;
        byte_t     hdr;
        byte_t     val;
    } pkt_t;

    localparam pkt_t PKT_NONE = '{kind: PK_NONE, hdr: '0, val: '0};

    // Work handed from the byte decision logic to the packet sequencer
    typedef struct packed {
        pkt_t             mid;
        pkt_t             fin;
        logic             defer_wr;
        byte_t            defer_byte;
        logic             row_done;
        logic [LEN_W-1:0] plen;
    } job_t;

    // One byte write into the literal store
    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        byte_t             data;
    } store_wr_t;

endpackage

FILE: rtl/br1rp_byte_if.sv
// Input channel of the row packer: one raw byte per item.
// Depends on br1rp_pkg for widths.
`timescale 1ns / 1ps
interface br1rp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [br1rp_pkg::BYTE_W-1:0] data_byte;
    logic                         row_end;

    modport source (output valid, output data_byte, output row_end, input ready);
    modport sink (input valid, input data_byte, input row_end, output ready);
endinterface

FILE: rtl/br1rp_word_if.sv
// Output channel of the row packer: one packed word per item.
// Depends on br1rp_pkg for widths.
`timescale 1ns / 1ps
interface br1rp_word_if;
    logic                         valid;
    logic                         ready;
    logic [br1rp_pkg::WORD_W-1:0] out_word;
    logic [br1rp_pkg::CNT_W-1:0]  out_count;
    logic                         step_last;
    logic                         row_done;
    logic [br1rp_pkg::LEN_W-1:0]  packed_length;

    modport source (output valid, output out_word, output out_count, output step_last,
                    output row_done, output packed_length, input ready);
    modport sink (input valid, input out_word, input out_count, input step_last,
                  input row_done, input packed_length, output ready);
endinterface

FILE: rtl/br1rp_ctrl.sv
// Byte decision logic: mode, fill, run start, previous byte and row length.
// Decides the packets of each accepted item. Depends on br1rp_pkg.
`timescale 1ns / 1ps
module br1rp_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [br1rp_pkg::BYTE_W-1:0] data_byte,
    input  logic                         row_end,
    output br1rp_pkg::job_t              job,
    output br1rp_pkg::store_wr_t         store_wr
);
    import br1rp_pkg::*;

    logic              run_mode_reg, run_mode_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] run_start_reg, run_start_next;
    byte_t             prev_reg, prev_next;
    logic              row_open_reg, row_open_next;
    logic [LEN_W-1:0]  emitted_reg, emitted_next;

    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] span;
    logic [LEN_W-1:0]  base_len;
    logic              wr_now;
    logic [FILL_W-1:0] wr_addr;
    logic              defer_wr;
    pkt_t              mid_pkt;
    pkt_t              fin_pkt;

    function automatic logic [LEN_W-1:0] pkt_len(pkt_t p);
        logic [LEN_W-1:0] len;
        case (p.kind)
            PK_LIT:  len = LEN_W'(p.hdr) + LEN_W'(2);
            PK_RUN:  len = LEN_W'(2);
            default: len = '0;
        endcase
        return len;
    endfunction

    assign fill_inc = fill_reg + FILL_W'(1);
    assign span     = fill_inc - run_start_reg;

    // Decide packets and next state for the byte at the input
    always_comb
    begin
        run_mode_next  = run_mode_reg;
        fill_next      = fill_reg;
        run_start_next = run_start_reg;
        prev_next      = prev_reg;
        row_open_next  = row_open_reg;
        base_len       = emitted_reg;
        wr_now         = 1'b0;
        wr_addr        = fill_reg;
        defer_wr       = 1'b0;
        mid_pkt        = PKT_NONE;
        fin_pkt        = PKT_NONE;

        if (!row_open_reg)
        begin
            // open a row with this byte alone in the store
            fill_next      = FILL_W'(1);
            run_start_next = '0;
            prev_next      = data_byte;
            run_mode_next  = 1'b0;
            base_len       = '0;
            row_open_next  = 1'b1;
            wr_now         = 1'b1;
            wr_addr        = '0;
        end
        else
        begin
            fill_next = fill_inc;
            if (!run_mode_reg)
            begin
                if (fill_reg < FILL_W'(STORE_DEPTH))
                begin
                    wr_now  = 1'b1;
                    wr_addr = fill_reg;
                end
                if (fill_inc > FILL_W'(LITERAL_MAX))
                begin
                    // store full: dump the first LITERAL_MAX bytes, restart
                    // the store after the dump has read entry zero
                    mid_pkt.kind   = PK_LIT;
                    mid_pkt.hdr    = fill_inc - FILL_W'(2);
                    fill_next      = FILL_W'(1);
                    run_start_next = '0;
                    defer_wr       = 1'b1;
                end
                else if (data_byte == prev_reg)
                begin
                    if (span >= FILL_W'(MIN_RUN))
                    begin
                        if (run_start_reg != '0)
                        begin
                            mid_pkt.kind = PK_LIT;
                            mid_pkt.hdr  = run_start_reg - FILL_W'(1);
                        end
                        run_mode_next = 1'b1;
                    end
                    else if (run_start_reg == '0)
                    begin
                        run_mode_next = 1'b1;
                    end
                end
                else
                begin
                    run_start_next = fill_reg;
                end
            end
            else
            begin
                if (data_byte != prev_reg || span > FILL_W'(RUN_MAX))
                begin
                    // close the run and restart the store with this byte
                    mid_pkt.kind   = PK_RUN;
                    mid_pkt.hdr    = run_start_reg + FILL_W'(2) - fill_inc;
                    mid_pkt.val    = prev_reg;
                    fill_next      = FILL_W'(1);
                    run_start_next = '0;
                    run_mode_next  = 1'b0;
                    wr_now         = 1'b1;
                    wr_addr        = '0;
                end
            end
            prev_next = data_byte;
        end

        if (row_end)
        begin
            // flush whatever is pending and close the row
            if (!run_mode_next)
            begin
                fin_pkt.kind = PK_LIT;
                fin_pkt.hdr  = fill_next - FILL_W'(1);
            end
            else
            begin
                fin_pkt.kind = PK_RUN;
                fin_pkt.hdr  = run_start_next + FILL_W'(1) - fill_next;
                fin_pkt.val  = prev_next;
            end
            row_open_next  = 1'b0;
            run_mode_next  = 1'b0;
            fill_next      = '0;
            run_start_next = '0;
        end
    end

    assign emitted_next = base_len + pkt_len(mid_pkt) + pkt_len(fin_pkt);

    assign job.mid        = mid_pkt;
    assign job.fin        = fin_pkt;
    assign job.defer_wr   = defer_wr;
    assign job.defer_byte = data_byte;
    assign job.row_done   = row_end;
    assign job.plen       = emitted_next;

    assign store_wr.en   = accept && wr_now;
    assign store_wr.row  = wr_addr[FILL_W-1:LANE_W];
    assign store_wr.lane = wr_addr[LANE_W-1:0];
    assign store_wr.data = data_byte;

    // Advance the row state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg  <= 1'b0;
            fill_reg      <= '0;
            run_start_reg <= '0;
            prev_reg      <= '0;
            row_open_reg  <= 1'b0;
            emitted_reg   <= '0;
        end
        else if (accept)
        begin
            run_mode_reg  <= run_mode_next;
            fill_reg      <= fill_next;
            run_start_reg <= run_start_next;
            prev_reg      <= prev_next;
            row_open_reg  <= row_open_next;
            emitted_reg   <= emitted_next;
        end
    end

endmodule

FILE: rtl/br1rp_store.sv
// Literal store: rows of OUT_LANES bytes, byte write, registered row read.
// Depends on br1rp_pkg.
`timescale 1ns / 1ps
module br1rp_store (
    input  logic                        clk,
    input  br1rp_pkg::store_wr_t        wr,
    input  logic                        rd_en,
    input  logic [br1rp_pkg::ROW_W-1:0] rd_row,
    output br1rp_pkg::row_t             rd_data
);
    import br1rp_pkg::*;

    row_t mem_arr [STORE_ROWS];
    row_t rd_data_reg;

    // Read returns the old row when the same row is written at the same edge
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_arr[wr.row][wr.lane] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_arr[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/br1rp_emit.sv
// Packet sequencer: reads the literal store row by row, builds output
// words and holds them in the output register. Depends on br1rp_pkg.
`timescale 1ns / 1ps
module br1rp_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  br1rp_pkg::job_t             job,
    output logic                        idle,
    output logic                        rd_en,
    output logic [br1rp_pkg::ROW_W-1:0] rd_row,
    input  br1rp_pkg::row_t             rd_data,
    output br1rp_pkg::store_wr_t        defer_wr,
    br1rp_word_if.source                pack_words
);
    import br1rp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_LIT   = 4'b0100,
        S_RUN   = 4'b1000
    } emit_state_t;

    emit_state_t       state_reg, state_next;
    pkt_t              cur_reg, cur_next;
    pkt_t              nxt_reg, nxt_next;
    logic              defer_reg, defer_next;
    byte_t             defer_byte_reg, defer_byte_next;
    logic              job_done_reg, job_done_next;
    logic [LEN_W-1:0]  job_len_reg, job_len_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic              first_reg, first_next;
    byte_t             carry_reg, carry_next;

    logic              out_valid_reg, out_valid_next;
    row_t              out_word_reg, out_word_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_last_reg, out_last_next;
    logic              out_done_reg, out_done_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              out_free;
    logic              lit_last;
    logic [CNT_W-1:0]  lit_cnt;
    row_t              raw_row;
    row_t              lit_word;
    row_t              run_word;
    logic              load;
    row_t              load_word;
    logic [CNT_W-1:0]  load_cnt;
    logic              pkt_done;
    logic              step_end;

    function automatic emit_state_t pkt_state(pkt_kind_t k);
        emit_state_t s;
        case (k)
            PK_LIT:  s = S_ISSUE;
            PK_RUN:  s = S_RUN;
            default: s = S_IDLE;
        endcase
        return s;
    endfunction

    assign idle     = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || pack_words.ready;
    assign lit_last = (rem_reg <= FILL_W'(OUT_LANES));
    assign lit_cnt  = lit_last ? rem_reg[CNT_W-1:0] : CNT_W'(OUT_LANES);

    // Build a literal word: header or carried byte, then seven store bytes
    always_comb
    begin
        raw_row[0] = first_reg ? cur_reg.hdr : carry_reg;
        for (int i = 1; i < OUT_LANES; i++)
        begin
            raw_row[i] = rd_data[i-1];
        end
        for (int i = 0; i < OUT_LANES; i++)
        begin
            lit_word[i] = (CNT_W'(i) < lit_cnt) ? raw_row[i] : '0;
        end
    end

    always_comb
    begin
        run_word    = '0;
        run_word[0] = cur_reg.hdr;
        run_word[1] = cur_reg.val;
    end

    // Sequence the packets of one item
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        defer_next      = defer_reg;
        defer_byte_next = defer_byte_reg;
        job_done_next   = job_done_reg;
        job_len_next    = job_len_reg;
        row_next        = row_reg;
        rem_next        = rem_reg;
        first_next      = first_reg;
        carry_next      = carry_reg;
        rd_en           = 1'b0;
        rd_row          = row_reg;
        load            = 1'b0;
        load_word       = lit_word;
        load_cnt        = lit_cnt;
        pkt_done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (job.mid.kind != PK_NONE)
                    begin
                        cur_next   = job.mid;
                        nxt_next   = job.fin;
                        state_next = pkt_state(job.mid.kind);
                    end
                    else
                    begin
                        cur_next   = job.fin;
                        nxt_next   = PKT_NONE;
                        state_next = pkt_state(job.fin.kind);
                    end
                    defer_next      = job.defer_wr;
                    defer_byte_next = job.defer_byte;
                    job_done_next   = job.row_done;
                    job_len_next    = job.plen;
                end
            end
            S_ISSUE:
            begin
                // read row zero; a pending store restart writes behind it
                rd_en      = 1'b1;
                rd_row     = '0;
                row_next   = ROW_W'(1);
                first_next = 1'b1;
                rem_next   = cur_reg.hdr + FILL_W'(2);
                defer_next = 1'b0;
                state_next = S_LIT;
            end
            S_LIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    carry_next = rd_data[OUT_LANES-1];
                    first_next = 1'b0;
                    if (!lit_last)
                    begin
                        rd_en    = 1'b1;
                        rd_row   = row_reg;
                        row_next = row_reg + ROW_W'(1);
                        rem_next = rem_reg - FILL_W'(OUT_LANES);
                    end
                    else
                    begin
                        pkt_done = 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_word = run_word;
                    load_cnt  = CNT_W'(2);
                    pkt_done  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the flush packet or drop back to idle
        if (pkt_done)
        begin
            if (nxt_reg.kind != PK_NONE)
            begin
                cur_next   = nxt_reg;
                nxt_next   = PKT_NONE;
                state_next = pkt_state(nxt_reg.kind);
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    assign step_end = pkt_done && (nxt_reg.kind == PK_NONE);

    assign defer_wr.en   = (state_reg == S_ISSUE) && defer_reg;
    assign defer_wr.row  = '0;
    assign defer_wr.lane = '0;
    assign defer_wr.data = defer_byte_reg;

    // Output register: load a new word or drop the taken one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_len_next   = out_len_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = load_word;
            out_count_next = load_cnt;
            out_last_next  = step_end;
            out_done_next  = step_end && job_done_reg;
            out_len_next   = (step_end && job_done_reg) ? job_len_reg : '0;
        end
        else if (pack_words.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= PKT_NONE;
            nxt_reg       <= PKT_NONE;
            defer_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            defer_reg     <= defer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        defer_byte_reg <= defer_byte_next;
        job_done_reg   <= job_done_next;
        job_len_reg    <= job_len_next;
        row_reg        <= row_next;
        rem_reg        <= rem_next;
        first_reg      <= first_next;
        carry_reg      <= carry_next;
        out_word_reg   <= out_word_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
        out_len_reg    <= out_len_next;
    end

    assign pack_words.valid         = out_valid_reg;
    assign pack_words.out_word      = out_word_reg;
    assign pack_words.out_count     = out_count_reg;
    assign pack_words.step_last     = out_last_reg;
    assign pack_words.row_done      = out_done_reg;
    assign pack_words.packed_length = out_len_reg;

endmodule

FILE: rtl/byterun1_row_packer_core.sv
// Channel     Dir  Item                  Payload
// row_bytes   in   one raw byte          data_byte, row_end
// pack_words  out  one packed word       out_word, out_count, step_last, row_done,
//                                        packed_length
//
// An item that sends nothing leaves the sequencer idle. Each literal packet of n bytes
// adds a read of store row zero plus ceil((n+1)/8) words, one store row read per
// word; each run packet adds one word. Output stalls hold the sequencer.
// Reset clears the control state only; the literal store holds no reset value
// and needs no clearing pass.
// Depends on br1rp_pkg, both channel interfaces and the assertion header.
`timescale 1ns / 1ps
`include "byterun1_row_packer_core_defines.svh"
module byterun1_row_packer_core (
    input  logic          clk,
    input  logic          rst_n,
    br1rp_byte_if.sink    row_bytes,
    br1rp_word_if.source  pack_words
);
    import br1rp_pkg::*;

    logic             accept;
    logic             idle;
    job_t             job;
    store_wr_t        acc_wr;
    store_wr_t        defer_wr;
    store_wr_t        store_wr;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    row_t             rd_data;

    // Take a byte only while the sequencer has no packet in flight
    assign row_bytes.ready = idle;
    assign accept          = row_bytes.valid && idle;

    br1rp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (row_bytes.data_byte),
        .row_end   (row_bytes.row_end),
        .job       (job),
        .store_wr  (acc_wr)
    );

    // Share the store write port between accept and deferred restart
    assign store_wr = acc_wr.en ? acc_wr : defer_wr;

    br1rp_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    br1rp_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .job        (job),
        .idle       (idle),
        .rd_en      (rd_en),
        .rd_row     (rd_row),
        .rd_data    (rd_data),
        .defer_wr   (defer_wr),
        .pack_words (pack_words)
    );

    `BR1RP_ASSERT(a_wr_port_single, !(acc_wr.en && defer_wr.en), "store write collision")
    `BR1RP_ASSERT(a_done_on_last, !(pack_words.valid && pack_words.row_done && !pack_words.step_last), "row_done without step_last")
    `BR1RP_ASSERT(a_len_on_done, !(pack_words.valid && !pack_words.row_done && (pack_words.packed_length != '0)), "length outside row end")
    `BR1RP_ASSERT_NEXT(a_row_end_busy, accept && row_bytes.row_end, !row_bytes.ready, "row end sent nothing")

endmodule
